@@ hw/rtl/fssh_pkg.sv @@
// shared types, constants and helpers of the fan speed selector
`timescale 1ns / 1ps

package fssh_pkg;

  localparam int TEMP_WIDTH_DEF = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 14;
  localparam int OFFSET_W       = 14;
  localparam int HYST_W         = 12;
  localparam int DIV_STEPS      = 9;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAN_TYPE   = 3'd0,
    CFG_HEAT_COOL  = 3'd1,
    CFG_PROP_BAND  = 3'd2,
    CFG_HYSTERESIS = 3'd3,
    CFG_THRESH_1   = 3'd4,
    CFG_THRESH_2   = 3'd5,
    CFG_THRESH_3   = 3'd6,
    CFG_OFFSET     = 3'd7
  } cfg_idx_t;

  localparam logic [1:0]          FAN_ONE_SPEED   = 2'd0;
  localparam logic [1:0]          FAN_TWO_SPEED   = 2'd1;
  localparam logic [1:0]          FAN_THREE_SPEED = 2'd2;
  localparam logic [1:0]          FAN_CONT        = 2'd3;

  localparam logic [1:0]          RST_FAN_TYPE   = FAN_THREE_SPEED;
  localparam logic                RST_HEAT_COOL  = 1'b0;
  localparam logic [7:0]          RST_PROP_BAND  = 8'd20;
  localparam logic [HYST_W-1:0]   RST_HYSTERESIS = 12'd50;
  localparam logic [7:0]          RST_THRESH_1   = 8'd5;
  localparam logic [7:0]          RST_THRESH_2   = 8'd10;
  localparam logic [7:0]          RST_THRESH_3   = 8'd20;
  localparam logic [OFFSET_W-1:0] RST_OFFSET     = 14'd0;

  typedef struct packed {
    logic load_in;
    logic calc_err;
    logic prep;
    logic div_step;
    logic step_calc;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic cont_mode;
  } dp_status_t;

  // stepped level = speed*255/(type+1), floored
  function automatic logic [7:0] step_level(input logic [1:0] ftype, input logic [1:0] spd);
    logic [7:0] lv;
    lv = 8'd0;
    case (ftype)
      FAN_ONE_SPEED: begin
        lv = (spd != 2'd0) ? 8'd255 : 8'd0;
      end
      FAN_TWO_SPEED: begin
        case (spd)
          2'd1:    lv = 8'd127;
          2'd2:    lv = 8'd255;
          default: lv = 8'd0;
        endcase
      end
      FAN_THREE_SPEED: begin
        case (spd)
          2'd1:    lv = 8'd85;
          2'd2:    lv = 8'd170;
          2'd3:    lv = 8'd255;
          default: lv = 8'd0;
        endcase
      end
      default: lv = 8'd0;
    endcase
    return lv;
  endfunction

endpackage

@@ hw/rtl/fssh_ctrl.sv @@
// controller state machine of the fan speed selector
`timescale 1ns / 1ps

module fssh_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  fssh_pkg::dp_status_t status,
  output fssh_pkg::dp_cmd_t    cmd
);
  import fssh_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_PREP,
    S_DIV,
    S_STEP,
    S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_xfer;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_ERR;
        end
      end
      S_ERR: begin
        cmd.calc_err = 1'b1;
        state_nxt    = status.cont_mode ? S_PREP : S_STEP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = CNT_W'(DIV_STEPS - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_STEP: begin
        cmd.step_calc = 1'b1;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // an accepted transfer always starts with the error cycle
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_ERR)
    else $error("accepted transfer did not start the error cycle");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while still pending");

  // divider count stays inside the step range
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> cnt_r <= CNT_W'(DIV_STEPS - 1))
    else $error("divider step count out of range");

  // a result only follows a finished computation
  a_fin_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |-> ($past(state_r) == S_DIV || $past(state_r) == S_STEP
                          || $past(state_r) == S_FIN))
    else $error("finish state entered without computation");

endmodule

@@ hw/rtl/fssh_dp.sv @@
// datapath of the fan speed selector: config registers, error, divider, step logic
`timescale 1ns / 1ps

module fssh_dp #(
  parameter int TEMP_WIDTH = fssh_pkg::TEMP_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fssh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fssh_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic signed [TEMP_WIDTH-1:0]    in_setpoint,
  input  logic signed [TEMP_WIDTH-1:0]    in_temperature,
  input  fssh_pkg::dp_cmd_t               cmd,
  output fssh_pkg::dp_status_t            status,
  output logic [7:0]                      out_fan_speed,
  output logic [7:0]                      out_fan_level,
  output logic [2:0]                      out_relay_mask
);
  import fssh_pkg::*;

  localparam int ERR_W = ((TEMP_WIDTH > OFFSET_W) ? TEMP_WIDTH : OFFSET_W) + 2;
  localparam int NUM_W = ERR_W + 8;

  // config registers
  logic [1:0]          fan_type_r;
  logic                heat_cool_r;
  logic [7:0]          prop_band_r;
  logic [HYST_W-1:0]   hyst_r;
  logic [7:0]          thr1_r, thr2_r, thr3_r;
  logic [OFFSET_W-1:0] offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fan_type_r  <= RST_FAN_TYPE;
      heat_cool_r <= RST_HEAT_COOL;
      prop_band_r <= RST_PROP_BAND;
      hyst_r      <= RST_HYSTERESIS;
      thr1_r      <= RST_THRESH_1;
      thr2_r      <= RST_THRESH_2;
      thr3_r      <= RST_THRESH_3;
      offset_r    <= RST_OFFSET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FAN_TYPE:   fan_type_r  <= cfg_wdata[1:0];
        CFG_HEAT_COOL:  heat_cool_r <= cfg_wdata[0];
        CFG_PROP_BAND:  prop_band_r <= cfg_wdata[7:0];
        CFG_HYSTERESIS: hyst_r      <= cfg_wdata[HYST_W-1:0];
        CFG_THRESH_1:   thr1_r      <= cfg_wdata[7:0];
        CFG_THRESH_2:   thr2_r      <= cfg_wdata[7:0];
        CFG_THRESH_3:   thr3_r      <= cfg_wdata[7:0];
        CFG_OFFSET:     offset_r    <= cfg_wdata[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  assign status.cont_mode = (fan_type_r == FAN_CONT);

  // input capture and demand error
  logic [TEMP_WIDTH-1:0] sp_r, tp_r;
  logic [ERR_W-1:0]      sp_x, tp_x, off_x, err_nxt;
  logic signed [ERR_W-1:0] err_r;

  assign sp_x  = {{(ERR_W-TEMP_WIDTH){sp_r[TEMP_WIDTH-1]}}, sp_r};
  assign tp_x  = {{(ERR_W-TEMP_WIDTH){tp_r[TEMP_WIDTH-1]}}, tp_r};
  assign off_x = {{(ERR_W-OFFSET_W){offset_r[OFFSET_W-1]}}, offset_r};
  assign err_nxt = heat_cool_r ? (tp_x - sp_x - off_x) : (sp_x - tp_x - off_x);

  // continuous mode: numerator 255*e and band*10
  logic [ERR_W-1:0]     e_pos;
  logic [NUM_W-1:0]     num;
  logic [7:0]           band;
  logic [11:0]          den;
  logic [NUM_W-1:0]     rem_r, dvs_r;
  logic [DIV_STEPS-1:0] q_r;
  logic                 q_bit;

  assign e_pos = err_r[ERR_W-1] ? '0 : err_r;
  assign num   = (NUM_W'(e_pos) << 8) - NUM_W'(e_pos);
  assign band  = (prop_band_r == 8'd0) ? 8'd1 : prop_band_r;
  assign den   = 12'({band, 3'b000}) + 12'({band, 1'b0});
  assign q_bit = (rem_r >= dvs_r);

  // stepped mode: up and down counts over the active thresholds
  logic [7:0]        thr [3];
  logic [11:0]       t10;
  logic [12:0]       t10h;
  logic [1:0]        up, down, nr, step_speed;
  logic [1:0]        step_speed_r;
  logic              err_pos;
  logic [7:0]        last_speed_r;

  assign thr[0] = thr1_r;
  assign thr[1] = thr2_r;
  assign thr[2] = thr3_r;
  assign nr      = fan_type_r + 2'd1;
  assign err_pos = !err_r[ERR_W-1] && (err_r != '0);

  always_comb begin
    up         = 2'd0;
    down       = nr;
    t10        = '0;
    t10h       = '0;
    for (int z = 0; z < 3; z++) begin
      t10  = 12'({thr[z], 3'b000}) + 12'({thr[z], 1'b0});
      t10h = 13'(t10) + 13'(hyst_r);
      if (2'(z) <= fan_type_r) begin
        if (err_r >= $signed({{(ERR_W-13){1'b0}}, t10h})) up = up + 2'd1;
        if (err_r <= $signed({{(ERR_W-12){1'b0}}, t10})) down = down - 2'd1;
      end
    end
    step_speed = last_speed_r[1:0];
    if (last_speed_r < 8'(up)) step_speed = up;
    if (last_speed_r > 8'(down)) step_speed = down;
    if (up == down) step_speed = down;
    if (!err_pos) step_speed = 2'd0;
  end

  // final result selection
  logic [7:0] fin_speed, fin_level;
  logic [2:0] fin_relay;

  always_comb begin
    if (status.cont_mode) begin
      fin_speed = q_r[DIV_STEPS-1] ? 8'd255 : q_r[7:0];
      fin_level = fin_speed;
      fin_relay = 3'd0;
    end else begin
      fin_speed = 8'(step_speed_r);
      fin_level = step_level(fan_type_r, step_speed_r);
      case (step_speed_r)
        2'd1:    fin_relay = 3'b001;
        2'd2:    fin_relay = 3'b010;
        2'd3:    fin_relay = 3'b100;
        default: fin_relay = 3'b000;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_speed_r <= '0;
    end else if (cmd.load_out) begin
      last_speed_r <= fin_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sp_r <= in_setpoint;
      tp_r <= in_temperature;
    end
    if (cmd.calc_err) begin
      err_r <= err_nxt;
    end
    if (cmd.prep) begin
      rem_r <= num;
      dvs_r <= NUM_W'(den) << (DIV_STEPS - 1);
      q_r   <= '0;
    end
    if (cmd.div_step) begin
      if (q_bit) rem_r <= rem_r - dvs_r;
      dvs_r <= dvs_r >> 1;
      q_r   <= {q_r[DIV_STEPS-2:0], q_bit};
    end
    if (cmd.step_calc) begin
      step_speed_r <= step_speed;
    end
    if (cmd.load_out) begin
      out_fan_speed  <= fin_speed;
      out_fan_level  <= fin_level;
      out_relay_mask <= fin_relay;
    end
  end

endmodule

@@ hw/rtl/fan_speed_selector_hysteresis.sv @@
// top level of the multi-speed fan selector with hysteresis
`timescale 1ns / 1ps

// Fan speed selector. Each input transfer carries a setpoint and a measured
// temperature (0.01 degC, two's complement) and yields exactly one result
// transfer with the fan speed, the scaled 0..255 level and the one-hot relay
// mask. The demand error is setpoint minus temperature minus the offset in
// heating, and temperature minus setpoint minus the offset in cooling. Fan
// type 0..2 selects stepped control with type+1 speeds: each threshold
// switches up at threshold*10 + hysteresis and down at threshold*10, starting
// from the last speed the block delivered. Fan type 3 gives a proportional
// level of 255*error/(band*10), clamped to 0..255, with a zero band taken as
// one. Items are handled one at a time: a stepped item runs the error, step and
// finish states, a continuous item the error, prepare, divide and finish states;
// the restoring divider resolves one quotient bit per cycle over 9 steps (the first
// step doubles as the saturation check). The result sits in an output
// register, so a new item is taken while the previous result still waits;
// the next result is held back until that one is taken. Configuration writes
// take effect at once and are meant for idle periods only.

module fan_speed_selector_hysteresis #(
  parameter int TEMP_WIDTH = fssh_pkg::TEMP_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [fssh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fssh_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // sample channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [TEMP_WIDTH-1:0]    in_setpoint,
  input  logic signed [TEMP_WIDTH-1:0]    in_temperature,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_fan_speed,
  output logic [7:0]                      out_fan_level,
  output logic [2:0]                      out_relay_mask
);
  import fssh_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  fssh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // config registers, error, serial divider, step logic and result register
  fssh_dp #(
    .TEMP_WIDTH (TEMP_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_setpoint    (in_setpoint),
    .in_temperature (in_temperature),
    .cmd            (cmd),
    .status         (status),
    .out_fan_speed  (out_fan_speed),
    .out_fan_level  (out_fan_level),
    .out_relay_mask (out_relay_mask)
  );

endmodule
